// File: src/scan_code_to_key_decoder_macros.svh
// Assertion helpers shared by the decoder RTL.
// Both forms sample on clk_i and are disabled while rst_ni is low.
`ifndef SCAN_CODE_TO_KEY_DECODER_MACROS_SVH
`define SCAN_CODE_TO_KEY_DECODER_MACROS_SVH

`ifndef SYNTHESIS

// Property must hold at every clock edge out of reset.
`define SC2K_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Same-cycle implication out of reset.
`define SC2K_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`else

`define SC2K_ASSERT(lbl, prop, msg)
`define SC2K_ASSERT_IMPL(lbl, ante, cons, msg)

`endif

`endif

// File: src/sc2k_pkg.sv
`timescale 1ns / 1ps

package sc2k_pkg;

  // Entries at or past this index read as no key in both columns
  localparam logic [7:0] TableEntries = 8'd89;

  // Prefix bytes
  localparam logic [7:0] PrefixE0 = 8'hE0;
  localparam logic [7:0] PrefixE1 = 8'hE1;

  // Scan indexes with special handling
  localparam logic [6:0] ScanLShift = 7'd42;
  localparam logic [6:0] ScanRShift = 7'd54;
  localparam logic [6:0] ScanCaps   = 7'd58;
  localparam logic [6:0] ScanNum    = 7'd69;
  localparam logic [6:0] ScanScroll = 7'd70;
  localparam logic [6:0] SymFirst   = 7'd2;
  localparam logic [6:0] SymLast    = 7'd53;
  localparam logic [6:0] PadFirst   = 7'd71;
  localparam logic [6:0] PadLast    = 7'd83;

  // Key codes
  localparam logic [7:0] CodeNone  = 8'h00;
  localparam logic [7:0] CodePause = 8'hA0;
  localparam logic [7:0] LetterLo  = 8'h61;
  localparam logic [7:0] LetterHi  = 8'h7A;

  localparam logic [2:0] SkipReset = 3'd2;

  // One decoded result
  typedef struct packed {
    logic       event_valid;
    logic [7:0] key_code;
    logic       key_pressed;
    logic       extended_key;
    logic       led_update;
    logic       caps_led;
    logic       num_led;
    logic       scroll_led;
  } result_t;

  // Set-1 key table: {normal, shifted}
  function automatic logic [15:0] key_pair(input logic [6:0] idx);
    logic [15:0] pair;
    unique case (idx)
      7'd0:  pair = 16'h0000;
      7'd1:  pair = 16'h1B1B;
      7'd2:  pair = 16'h3121;
      7'd3:  pair = 16'h3240;
      7'd4:  pair = 16'h3323;
      7'd5:  pair = 16'h3424;
      7'd6:  pair = 16'h3525;
      7'd7:  pair = 16'h365E;
      7'd8:  pair = 16'h3726;
      7'd9:  pair = 16'h382A;
      7'd10: pair = 16'h3928;
      7'd11: pair = 16'h3029;
      7'd12: pair = 16'h2D5F;
      7'd13: pair = 16'h3D2B;
      7'd14: pair = 16'h0808;
      7'd15: pair = 16'h0909;
      7'd16: pair = 16'h7151;
      7'd17: pair = 16'h7757;
      7'd18: pair = 16'h6545;
      7'd19: pair = 16'h7252;
      7'd20: pair = 16'h7454;
      7'd21: pair = 16'h7959;
      7'd22: pair = 16'h7555;
      7'd23: pair = 16'h6949;
      7'd24: pair = 16'h6F4F;
      7'd25: pair = 16'h7050;
      7'd26: pair = 16'h5B7B;
      7'd27: pair = 16'h5D7D;
      7'd28: pair = 16'h0A0A;
      7'd29: pair = 16'h8181;
      7'd30: pair = 16'h6141;
      7'd31: pair = 16'h7353;
      7'd32: pair = 16'h6444;
      7'd33: pair = 16'h6646;
      7'd34: pair = 16'h6747;
      7'd35: pair = 16'h6848;
      7'd36: pair = 16'h6A4A;
      7'd37: pair = 16'h6B4B;
      7'd38: pair = 16'h6C4C;
      7'd39: pair = 16'h3B3A;
      7'd40: pair = 16'h2722;
      7'd41: pair = 16'h607E;
      7'd42: pair = 16'h8282;
      7'd43: pair = 16'h5C7C;
      7'd44: pair = 16'h7A5A;
      7'd45: pair = 16'h7858;
      7'd46: pair = 16'h6343;
      7'd47: pair = 16'h7656;
      7'd48: pair = 16'h6242;
      7'd49: pair = 16'h6E4E;
      7'd50: pair = 16'h6D4D;
      7'd51: pair = 16'h2C3C;
      7'd52: pair = 16'h2E3E;
      7'd53: pair = 16'h2F3F;
      7'd54: pair = 16'h8383;
      7'd55: pair = 16'h2A2A;
      7'd56: pair = 16'h8585;
      7'd57: pair = 16'h2020;
      7'd58: pair = 16'h8686;
      7'd59: pair = 16'h8787;
      7'd60: pair = 16'h8888;
      7'd61: pair = 16'h8989;
      7'd62: pair = 16'h8A8A;
      7'd63: pair = 16'h8B8B;
      7'd64: pair = 16'h8C8C;
      7'd65: pair = 16'h8D8D;
      7'd66: pair = 16'h8E8E;
      7'd67: pair = 16'h8F8F;
      7'd68: pair = 16'h9090;
      7'd69: pair = 16'h9191;
      7'd70: pair = 16'h9292;
      7'd71: pair = 16'h9337;
      7'd72: pair = 16'h9438;
      7'd73: pair = 16'h9539;
      7'd74: pair = 16'h2D2D;
      7'd75: pair = 16'h9634;
      7'd76: pair = 16'h9735;
      7'd77: pair = 16'h9836;
      7'd78: pair = 16'h2B2B;
      7'd79: pair = 16'h9931;
      7'd80: pair = 16'h9A32;
      7'd81: pair = 16'h9B33;
      7'd82: pair = 16'h9C30;
      7'd83: pair = 16'h9D2E;
      7'd87: pair = 16'h9E9E;
      7'd88: pair = 16'h9F9F;
      default: pair = 16'h0000;
    endcase
    return pair;
  endfunction

endpackage

// File: src/sc2k_decode.sv
`timescale 1ns / 1ps

// Decodes one scan byte against the lock/prefix state and advances that
// state when the byte moves on to the result register.
module sc2k_decode (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             advance_i,
  input  logic [7:0]       scan_code_i,
  input  logic [2:0]       pause_skip_count_i,
  output sc2k_pkg::result_t result_o
);
  import sc2k_pkg::*;

  logic       shift_q, shift_d;
  logic       caps_q, caps_d;
  logic       num_q, num_d;
  logic       scroll_q, scroll_d;
  logic       ext_q, ext_d;
  logic [2:0] skip_q, skip_d;

  logic [6:0]  idx;
  logic [15:0] pair;
  logic [7:0]  code_norm;
  logic [7:0]  code_shft;
  logic        is_letter;
  logic        use_shifted;
  logic        pressed;

  // Table lookup, with the out-of-table range forced to no key
  assign idx       = scan_code_i[6:0];
  assign pair      = ({1'b0, idx} < TableEntries) ? key_pair(idx) : 16'h0000;
  assign code_norm = pair[15:8];
  assign code_shft = pair[7:0];
  assign is_letter = (code_norm >= LetterLo) && (code_norm <= LetterHi);
  assign pressed   = ~scan_code_i[7];

  // Column select
  always_comb begin
    if (is_letter) begin
      use_shifted = shift_q ^ caps_q;
    end else if ((idx >= SymFirst) && (idx <= SymLast)) begin
      use_shifted = shift_q;
    end else if ((idx >= PadFirst) && (idx <= PadLast) && !ext_q) begin
      use_shifted = num_q;
    end else begin
      use_shifted = 1'b0;
    end
  end

  // Result and next state
  always_comb begin
    shift_d  = shift_q;
    caps_d   = caps_q;
    num_d    = num_q;
    scroll_d = scroll_q;
    ext_d    = ext_q;
    skip_d   = skip_q;

    result_o              = '0;
    result_o.key_code     = CodeNone;

    if (skip_q != 3'd0) begin
      skip_d = skip_q - 3'd1;
    end else if (scan_code_i == PrefixE1) begin
      result_o.event_valid = 1'b1;
      result_o.key_code    = CodePause;
      result_o.key_pressed = 1'b1;
      skip_d               = pause_skip_count_i;
    end else if (scan_code_i == PrefixE0) begin
      ext_d = 1'b1;
    end else begin
      result_o.event_valid  = 1'b1;
      result_o.key_code     = use_shifted ? code_shft : code_norm;
      result_o.key_pressed  = pressed;
      result_o.extended_key = ext_q;
      ext_d                 = 1'b0;
      if ((idx == ScanLShift) || (idx == ScanRShift)) begin
        shift_d = pressed;
      end else if (pressed && (idx == ScanCaps)) begin
        caps_d              = ~caps_q;
        result_o.led_update = 1'b1;
      end else if (pressed && (idx == ScanNum)) begin
        num_d               = ~num_q;
        result_o.led_update = 1'b1;
      end else if (pressed && (idx == ScanScroll)) begin
        scroll_d            = ~scroll_q;
        result_o.led_update = 1'b1;
      end
    end

    // LEDs show the lock state after this byte
    result_o.caps_led   = caps_d;
    result_o.num_led    = num_d;
    result_o.scroll_led = scroll_d;
  end

  // Decoder state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shift_q  <= 1'b0;
      caps_q   <= 1'b0;
      num_q    <= 1'b0;
      scroll_q <= 1'b0;
      ext_q    <= 1'b0;
      skip_q   <= 3'd0;
    end else if (advance_i) begin
      shift_q  <= shift_d;
      caps_q   <= caps_d;
      num_q    <= num_d;
      scroll_q <= scroll_d;
      ext_q    <= ext_d;
      skip_q   <= skip_d;
    end
  end

endmodule

// File: src/scan_code_to_key_decoder.sv
`timescale 1ns / 1ps
`include "scan_code_to_key_decoder_macros.svh"

// PS/2 set-1 scan byte decoder. Every byte accepted gives exactly one
// result: a key event (ASCII or special key code, press/release, E0 flag,
// LED update request and the current lock LEDs) or a non-event for E0
// prefixes and the bytes skipped after an E1 pause prefix. One byte is
// accepted per clock while the input is not stalled; an accepted byte is held
// in the input register, decoded from it, and moves into the result register
// once that register is empty or its result is taken. Only the output side's
// stall slows the flow. The pause skip count is written through the cfg port,
// which is always ready; write it only while no bytes are in flight. It
// resets to 2.
module scan_code_to_key_decoder (
  input  logic       clk_i,
  input  logic       rst_ni,
  // configuration write
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [2:0] pause_skip_count_i,
  // scan byte input
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] scan_code_i,
  // result output
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic       event_valid_o,
  output logic [7:0] key_code_o,
  output logic       key_pressed_o,
  output logic       extended_key_o,
  output logic       led_update_o,
  output logic       caps_led_o,
  output logic       num_led_o,
  output logic       scroll_led_o
);
  import sc2k_pkg::*;

  logic [2:0] skip_cfg_q;
  logic       in_valid_q;
  logic [7:0] scan_q;
  logic       out_valid_q;
  result_t    result_q;
  result_t    result_d;
  logic       out_ready;
  logic       in_ready;
  logic       advance;

  // Configuration register
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      skip_cfg_q <= SkipReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      skip_cfg_q <= pause_skip_count_i;
    end
  end

  // Flow control: result register frees when empty or taken
  assign out_ready  = !out_valid_q || !out_stall_i;
  assign advance    = in_valid_q && out_ready;
  assign in_ready   = !in_valid_q || out_ready;
  assign in_stall_o = !in_ready;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready && in_valid_i) begin
      scan_q <= scan_code_i;
    end
  end

  sc2k_decode u_decode (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .advance_i          (advance),
    .scan_code_i        (scan_q),
    .pause_skip_count_i (skip_cfg_q),
    .result_o           (result_d)
  );

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_ready) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      result_q <= result_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign event_valid_o  = result_q.event_valid;
  assign key_code_o     = result_q.key_code;
  assign key_pressed_o  = result_q.key_pressed;
  assign extended_key_o = result_q.extended_key;
  assign led_update_o   = result_q.led_update;
  assign caps_led_o     = result_q.caps_led;
  assign num_led_o      = result_q.num_led;
  assign scroll_led_o   = result_q.scroll_led;

  // Checks
  `SC2K_ASSERT(a_stall_only_when_full, !in_stall_o || (in_valid_q && out_valid_o && out_stall_i), "input stalled without a blocked result")
  `SC2K_ASSERT_IMPL(a_led_needs_press, out_valid_o && led_update_o, event_valid_o && key_pressed_o, "LED update on a non-press result")
  `SC2K_ASSERT_IMPL(a_nonevent_clear, out_valid_o && !event_valid_o, (key_code_o == CodeNone) && !key_pressed_o && !extended_key_o && !led_update_o, "non-event result carries key data")
  `SC2K_ASSERT_IMPL(a_pause_not_ext, out_valid_o && event_valid_o && (key_code_o == CodePause), key_pressed_o && !extended_key_o, "pause event with wrong flags")

endmodule
